>>> hdl/gpfd_pkg.sv
// Shared types, constants and decode functions for the game pad poll frame decoder.
package gpfd_pkg;

	localparam logic [7:0] ID_DIGITAL = 8'h41;
	localparam logic [7:0] ID_ANALOG  = 8'h73;

	// frame has nine bytes, positions 0..8
	localparam int unsigned POS_W    = 4;
	localparam logic [POS_W-1:0] POS_FIRST = 4'd0;
	localparam logic [POS_W-1:0] POS_LAST  = 4'd8;

	localparam int unsigned NUM_BUTTONS = 12;

	// stored bytes 1..7, slot k holds frame byte k+1
	localparam int unsigned NUM_SLOTS = 7;
	localparam logic [2:0] SLOT_ID    = 3'd0;
	localparam logic [2:0] SLOT_BTN1  = 3'd2;
	localparam logic [2:0] SLOT_BTN2  = 3'd3;
	localparam logic [2:0] SLOT_RX    = 3'd4;
	localparam logic [2:0] SLOT_RY    = 3'd5;
	localparam logic [2:0] SLOT_LX    = 3'd6;

	localparam logic [3:0] HAT_CENTER     = 4'd0;
	localparam logic [3:0] HAT_UP         = 4'd1;
	localparam logic [3:0] HAT_UP_RIGHT   = 4'd2;
	localparam logic [3:0] HAT_RIGHT      = 4'd3;
	localparam logic [3:0] HAT_DOWN_RIGHT = 4'd4;
	localparam logic [3:0] HAT_DOWN       = 4'd5;
	localparam logic [3:0] HAT_DOWN_LEFT  = 4'd6;
	localparam logic [3:0] HAT_LEFT       = 4'd7;
	localparam logic [3:0] HAT_UP_LEFT    = 4'd8;

	localparam logic [15:0] AXIS_MID = 16'd32767;

	typedef logic [NUM_SLOTS-1:0][7:0] frame_t;
	typedef logic [NUM_BUTTONS-1:0]    buttons_t;

	typedef struct packed {
		logic               ok;
		buttons_t           buttons;
		buttons_t           changed;
		logic [3:0]         hat;
		logic signed [15:0] lx;
		logic signed [15:0] ly;
		logic signed [15:0] rx;
		logic signed [15:0] ry;
	} result_t;

	// x*65534/255 equals 257*x - (x != 0) for 8-bit x, then recenter
	function automatic logic signed [15:0] scale_axis(input logic [7:0] x);
		logic [15:0] v;
		begin
			v = {x, x} - {15'd0, |x};
			return signed'(v - AXIS_MID);
		end
	endfunction

	// dpad bits of the inverted first button byte; diagonals win
	function automatic logic [3:0] hat_of(input logic [7:0] b1);
		logic up, right, down, left;
		begin
			up    = b1[4];
			right = b1[5];
			down  = b1[6];
			left  = b1[7];
			if (up && right)
				return HAT_UP_RIGHT;
			else if (up && left)
				return HAT_UP_LEFT;
			else if (down && right)
				return HAT_DOWN_RIGHT;
			else if (down && left)
				return HAT_DOWN_LEFT;
			else if (up)
				return HAT_UP;
			else if (down)
				return HAT_DOWN;
			else if (left)
				return HAT_LEFT;
			else if (right)
				return HAT_RIGHT;
			else
				return HAT_CENTER;
		end
	endfunction

	function automatic buttons_t map_buttons(input logic [7:0] b1, input logic [7:0] b2);
		buttons_t m;
		begin
			m[0]  = b2[7]; // square
			m[1]  = b2[6]; // x
			m[2]  = b2[5]; // circle
			m[3]  = b2[4]; // triangle
			m[4]  = b2[2]; // l1
			m[5]  = b2[3]; // r1
			m[6]  = b2[0]; // l2
			m[7]  = b2[1]; // r2
			m[8]  = b1[0]; // select
			m[9]  = b1[3]; // start
			m[10] = b1[1]; // l3
			m[11] = b1[2]; // r3
			return m;
		end
	endfunction

endpackage

>>> hdl/gpfd_decode.sv
// Frame decode: ID check, button map, change mask, hat code and stick scaling.
module gpfd_decode (
	input  gpfd_pkg::frame_t   frame,
	input  logic [7:0]         last_byte,
	input  gpfd_pkg::buttons_t prev_buttons,
	output gpfd_pkg::result_t  result
);

	logic              id_ok;
	logic [7:0]        b1;
	logic [7:0]        b2;
	gpfd_pkg::buttons_t cur;

	assign id_ok = (frame[gpfd_pkg::SLOT_ID] == gpfd_pkg::ID_DIGITAL) ||
		(frame[gpfd_pkg::SLOT_ID] == gpfd_pkg::ID_ANALOG);
	assign b1  = ~frame[gpfd_pkg::SLOT_BTN1];
	assign b2  = ~frame[gpfd_pkg::SLOT_BTN2];
	assign cur = gpfd_pkg::map_buttons(b1, b2);

	always_comb begin
		result = '0;
		if (id_ok) begin
			result.ok      = 1'b1;
			result.buttons = cur;
			result.changed = cur ^ prev_buttons;
			result.hat     = gpfd_pkg::hat_of(b1);
			result.lx      = gpfd_pkg::scale_axis(frame[gpfd_pkg::SLOT_LX]);
			result.ly      = gpfd_pkg::scale_axis(last_byte);
			result.rx      = gpfd_pkg::scale_axis(frame[gpfd_pkg::SLOT_RX]);
			result.ry      = gpfd_pkg::scale_axis(frame[gpfd_pkg::SLOT_RY]);
		end
	end

endmodule

>>> hdl/gamepad_poll_frame_decoder.sv
// Top level: game pad poll frame decoder, one rx beat per byte, one result beat per frame.
// Latency: the result beat is valid the cycle after the ninth byte's beat is accepted.
// Throughput: one byte beat per cycle; a frame of nine beats yields one result beat.
// Only a beat arriving while the counter sits at the ninth byte waits on a full, stalled
// result register; other bytes flow on.
// Reset (arst_n low, async): position to 0, button history to none pressed, no result.
module gamepad_poll_frame_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	input  logic               frame_start,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               frame_ok,
	output logic [11:0]        button_state,
	output logic [11:0]        button_changed,
	output logic [3:0]         hat_code,
	output logic signed [15:0] left_x,
	output logic signed [15:0] left_y,
	output logic signed [15:0] right_x,
	output logic signed [15:0] right_y
);

	// position of the next byte within the frame
	logic [gpfd_pkg::POS_W-1:0] pos_q;
	logic [gpfd_pkg::POS_W-1:0] pos_eff;
	// bytes 1..7 of the frame being received; no reset, always written before read
	gpfd_pkg::frame_t           frame_q;
	// mapped buttons of the last valid frame
	gpfd_pkg::buttons_t         prev_q;
	// result register
	logic                       out_valid_q;
	gpfd_pkg::result_t          result_q;
	gpfd_pkg::result_t          result_d;

	logic in_fire;
	logic last_fire;
	logic out_fire;

	// frame_start or a stray position restarts at byte 0
	assign pos_eff = (frame_start || (pos_q > gpfd_pkg::POS_LAST)) ?
		gpfd_pkg::POS_FIRST : pos_q;

	// Only a ninth byte needs result space. Stall is kept off the input
	// payload and taken from the counter alone, so it may also hold back a
	// frame_start beat that arrives when the counter sits at the last byte.
	assign in_stall  = out_valid_q && out_stall && (pos_q == gpfd_pkg::POS_LAST);
	assign in_fire   = in_valid && !in_stall;
	assign last_fire = in_fire && (pos_eff == gpfd_pkg::POS_LAST);
	assign out_fire  = out_valid_q && !out_stall;

	gpfd_decode u_decode (
		.frame        (frame_q),
		.last_byte    (rx_byte),
		.prev_buttons (prev_q),
		.result       (result_d)
	);

	// position counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= gpfd_pkg::POS_FIRST;
		end else if (in_fire) begin
			if (pos_eff == gpfd_pkg::POS_LAST)
				pos_q <= gpfd_pkg::POS_FIRST;
			else
				pos_q <= pos_eff + 4'd1;
		end
	end

	// byte capture, positions 1..7 into slots 0..6
	always_ff @(posedge clk) begin
		if (in_fire && (pos_eff != gpfd_pkg::POS_FIRST) &&
			(pos_eff != gpfd_pkg::POS_LAST)) begin
			frame_q[3'(pos_eff - 4'd1)] <= rx_byte;
		end
	end

	// button history moves only on a valid frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (last_fire && result_d.ok) begin
			prev_q <= result_d.buttons;
		end
	end

	// result register: load on the ninth byte, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (last_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (last_fire) begin
			result_q <= result_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign frame_ok       = result_q.ok;
	assign button_state   = result_q.buttons;
	assign button_changed = result_q.changed;
	assign hat_code       = result_q.hat;
	assign left_x         = result_q.lx;
	assign left_y         = result_q.ly;
	assign right_x        = result_q.rx;
	assign right_y        = result_q.ry;

	// the counter never leaves the nine-byte frame
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= gpfd_pkg::POS_LAST)
		else $error("frame position out of range");

	// a ninth byte always yields a result beat next cycle
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		last_fire |=> out_valid)
		else $error("ninth byte produced no result");

	// a rejected frame reports nothing but zeros
	a_bad_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !frame_ok) |-> ((button_state == '0) && (button_changed == '0) &&
		(hat_code == gpfd_pkg::HAT_CENTER)))
		else $error("rejected frame carries data");

	// a rejected frame leaves the button history alone
	a_bad_frame_keeps_prev: assert property (@(posedge clk) disable iff (!arst_n)
		(last_fire && !result_d.ok) |=> (prev_q == $past(prev_q)))
		else $error("button history moved on rejected frame");

endmodule
